### sv/sqp_pkg.sv
// shared widths, payload structs and status codes for the square to quad setup pipeline
// no dependencies
`default_nettype none

package sqp_pkg;

    localparam int IN_W    = 28;   // corner coordinate width
    localparam int TOL_W   = 16;   // planar tolerance register width
    localparam int CW      = 48;   // linear coefficient width
    localparam int PW      = 32;   // perspective term width
    localparam int PFRAC   = 24;   // perspective term fraction bits
    localparam int MXW     = IN_W + 2;   // corner-sum mismatch
    localparam int EW      = IN_W + 1;   // edge difference
    localparam int BW      = IN_W + 1;   // base coefficient
    localparam int PRW     = MXW + EW;   // product of mismatch and edge
    localparam int NW      = PRW + 1;    // numerator and denominator
    localparam int MW      = NW;         // their magnitudes
    localparam int QW      = 33;         // quotient bits, 8 integer and 25 fraction
    localparam int DW      = MW + 8;     // divider remainder and shifted divisor
    localparam int GPW     = PW + IN_W;  // perspective term times coordinate
    localparam int RW      = GPW - PFRAC; // rounded product

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_EDGE = 2'd1;
    localparam logic [1:0] ST_SING = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;

    typedef logic signed [IN_W-1:0] t_coord;

    // per-quad values that ride along with the division
    typedef struct packed {
        t_coord                x0;
        t_coord                y0;
        t_coord                x1;
        t_coord                y1;
        t_coord                x3;
        t_coord                y3;
        logic signed [BW-1:0]  ba;
        logic signed [BW-1:0]  bb;
        logic signed [BW-1:0]  bd;
        logic signed [BW-1:0]  be;
        logic                  proj;
        logic                  sing;
    } t_ctx;

    // one restoring divider lane
    typedef struct packed {
        logic [DW-1:0] r;
        logic [QW-1:0] q;
    } t_quo;

    // state passed between divider steps
    typedef struct packed {
        t_quo          u;
        t_quo          v;
        logic [DW-1:0] dsh;
        logic          neg_u;
        logic          neg_v;
        logic          ovf_u;
        logic          ovf_v;
        t_ctx          ctx;
    } t_div;

    // one finished result
    typedef struct packed {
        logic signed [CW-1:0] u_dx;
        logic signed [CW-1:0] u_dy;
        logic signed [CW-1:0] v_dx;
        logic signed [CW-1:0] v_dy;
        t_coord               ox;
        t_coord               oy;
        logic signed [PW-1:0] pu;
        logic signed [PW-1:0] pv;
        logic                 proj;
        logic [1:0]           status;
    } t_res;

endpackage

`default_nettype wire

### sv/sqp_front.sv
// front stages: differences, affine test, products, numerators, magnitudes, divider setup
// depends on sqp_pkg
`default_nettype none

module sqp_front
    import sqp_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_en,
    input  wire              i_valid,
    input  wire [TOL_W-1:0]  i_tol,
    input  wire t_coord      i_ul_x,
    input  wire t_coord      i_ul_y,
    input  wire t_coord      i_ur_x,
    input  wire t_coord      i_ur_y,
    input  wire t_coord      i_ll_x,
    input  wire t_coord      i_ll_y,
    input  wire t_coord      i_lr_x,
    input  wire t_coord      i_lr_y,
    output logic             o_valid,
    output t_div             o_div
);

    logic [4:0] r_v;

    // stage 1
    t_coord                r1_x0, r1_y0, r1_x1, r1_y1, r1_x2, r1_y2, r1_x3, r1_y3;
    logic signed [MXW-1:0] r1_mx, r1_my;
    logic signed [EW-1:0]  r1_e1x, r1_e1y, r1_e2x, r1_e2y;
    // stage 2
    logic signed [PRW-1:0] r2_p0, r2_p1, r2_p2, r2_p3, r2_p4, r2_p5;
    t_ctx                  r2_ctx;
    // stage 3
    logic signed [NW-1:0]  r3_den, r3_nu, r3_nv;
    t_ctx                  r3_ctx;
    // stage 4
    logic [MW-1:0]         r4_dm, r4_um, r4_vm;
    logic                  r4_neg_u, r4_neg_v;
    t_ctx                  r4_ctx;
    // stage 5
    t_div                  r5_div;

    logic [MXW-1:0]        w_amx, w_amy;
    logic                  w_proj;
    t_ctx                  w_ctx2;
    logic [MW-1:0]         w_dm, w_um, w_vm;
    t_ctx                  w_ctx4;

    // valid bits move with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    // stage 1: mismatch sums and edge vectors
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_x0  <= i_ul_x;
            r1_y0  <= i_ul_y;
            r1_x1  <= i_ur_x;
            r1_y1  <= i_ur_y;
            r1_x2  <= i_lr_x;
            r1_y2  <= i_lr_y;
            r1_x3  <= i_ll_x;
            r1_y3  <= i_ll_y;
            r1_mx  <= MXW'(i_ul_x) - MXW'(i_ur_x) + MXW'(i_lr_x) - MXW'(i_ll_x);
            r1_my  <= MXW'(i_ul_y) - MXW'(i_ur_y) + MXW'(i_lr_y) - MXW'(i_ll_y);
            r1_e1x <= EW'(i_ur_x) - EW'(i_lr_x);
            r1_e1y <= EW'(i_ur_y) - EW'(i_lr_y);
            r1_e2x <= EW'(i_ll_x) - EW'(i_lr_x);
            r1_e2y <= EW'(i_ll_y) - EW'(i_lr_y);
        end
    end

    // affine test against the tolerance and base coefficients
    always_comb begin
        w_amx  = r1_mx[MXW-1] ? MXW'(-r1_mx) : MXW'(r1_mx);
        w_amy  = r1_my[MXW-1] ? MXW'(-r1_my) : MXW'(r1_my);
        w_proj = !((w_amx <= MXW'(i_tol)) && (w_amy <= MXW'(i_tol)));
        w_ctx2.x0   = r1_x0;
        w_ctx2.y0   = r1_y0;
        w_ctx2.x1   = r1_x1;
        w_ctx2.y1   = r1_y1;
        w_ctx2.x3   = r1_x3;
        w_ctx2.y3   = r1_y3;
        w_ctx2.ba   = BW'(r1_x1) - BW'(r1_x0);
        w_ctx2.bd   = BW'(r1_y1) - BW'(r1_y0);
        w_ctx2.bb   = w_proj ? BW'(r1_x3) - BW'(r1_x0) : BW'(r1_x2) - BW'(r1_x1);
        w_ctx2.be   = w_proj ? BW'(r1_y3) - BW'(r1_y0) : BW'(r1_y2) - BW'(r1_y1);
        w_ctx2.proj = w_proj;
        w_ctx2.sing = 1'b0;
    end

    // stage 2: the six cross products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_p0  <= PRW'(r1_e1x) * PRW'(r1_e2y);
            r2_p1  <= PRW'(r1_e1y) * PRW'(r1_e2x);
            r2_p2  <= PRW'(r1_mx) * PRW'(r1_e2y);
            r2_p3  <= PRW'(r1_my) * PRW'(r1_e2x);
            r2_p4  <= PRW'(r1_e1x) * PRW'(r1_my);
            r2_p5  <= PRW'(r1_e1y) * PRW'(r1_mx);
            r2_ctx <= w_ctx2;
        end
    end

    // stage 3: denominator and both numerators
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_den <= NW'(r2_p0) - NW'(r2_p1);
            r3_nu  <= NW'(r2_p2) - NW'(r2_p3);
            r3_nv  <= NW'(r2_p4) - NW'(r2_p5);
            r3_ctx <= r2_ctx;
        end
    end

    // stage 4: magnitudes, quotient signs, singular check
    always_comb begin
        w_dm = r3_den[NW-1] ? MW'(-r3_den) : MW'(r3_den);
        w_um = r3_nu[NW-1]  ? MW'(-r3_nu)  : MW'(r3_nu);
        w_vm = r3_nv[NW-1]  ? MW'(-r3_nv)  : MW'(r3_nv);
        w_ctx4      = r3_ctx;
        w_ctx4.sing = r3_ctx.proj && (r3_den == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_dm       <= w_dm;
            r4_um       <= w_um;
            r4_vm       <= w_vm;
            r4_neg_u    <= r3_nu[NW-1] ^ r3_den[NW-1];
            r4_neg_v    <= r3_nv[NW-1] ^ r3_den[NW-1];
            r4_ctx      <= w_ctx4;
        end
    end

    // stage 5: integer overflow check and divider start values
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_div.u.r   <= DW'(r4_um);
            r5_div.u.q   <= '0;
            r5_div.v.r   <= DW'(r4_vm);
            r5_div.v.q   <= '0;
            r5_div.dsh   <= DW'(r4_dm) << 7;
            r5_div.ovf_u <= DW'(r4_um) >= (DW'(r4_dm) << 8);
            r5_div.ovf_v <= DW'(r4_vm) >= (DW'(r4_dm) << 8);
            r5_div.neg_u <= r4_neg_u;
            r5_div.neg_v <= r4_neg_v;
            r5_div.ctx   <= r4_ctx;
        end
    end

    assign o_valid = r_v[4];
    assign o_div   = r5_div;

endmodule

`default_nettype wire

### sv/sqp_div_step.sv
// one restoring division step for both perspective quotients
// depends on sqp_pkg
`default_nettype none

module sqp_div_step
    import sqp_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_en,
    input  wire        i_valid,
    input  wire t_div  i_st,
    output logic       o_valid,
    output t_div       o_st
);

    logic r_v;
    t_div r_st;
    t_div w_nx;

    // compare, subtract when it fits, shift remainder, append quotient bit
    function automatic t_quo step(input t_quo s, input logic [DW-1:0] d);
        logic [DW:0] diff;
        t_quo        o;
        diff = {1'b0, s.r} - {1'b0, d};
        if (!diff[DW]) begin
            o.r = {diff[DW-2:0], 1'b0};
        end else begin
            o.r = {s.r[DW-2:0], 1'b0};
        end
        o.q = {s.q[QW-2:0], ~diff[DW]};
        return o;
    endfunction

    always_comb begin
        w_nx   = i_st;
        w_nx.u = step(i_st.u, i_st.dsh);
        w_nx.v = step(i_st.v, i_st.dsh);
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= w_nx;
        end
    end

    assign o_valid = r_v;
    assign o_st    = r_st;

endmodule

`default_nettype wire

### sv/sqp_back.sv
// back stages: quotient rounding and clamp, perspective products, final coefficients
// depends on sqp_pkg
`default_nettype none

module sqp_back
    import sqp_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_en,
    input  wire        i_valid,
    input  wire t_div  i_div,
    output logic       o_valid,
    output t_res       o_res
);

    typedef struct packed {
        logic [PW-1:0] val;
        logic          sat;
    } t_pq;

    logic [3:0] r_v;

    // stage 1
    logic signed [PW-1:0]  r1_g, r1_h;
    logic                  r1_sat;
    t_ctx                  r1_ctx;
    // stage 2
    logic signed [GPW-1:0] r2_pa, r2_pd, r2_pb, r2_pe;
    logic signed [PW-1:0]  r2_g, r2_h;
    logic                  r2_sat;
    t_ctx                  r2_ctx;
    // stage 3
    logic signed [RW-1:0]  r3_ra, r3_rd, r3_rb, r3_re;
    logic signed [PW-1:0]  r3_g, r3_h;
    logic                  r3_sat;
    t_ctx                  r3_ctx;
    // stage 4
    logic signed [CW-1:0]  r4_a, r4_b, r4_d, r4_e;
    logic signed [PW-1:0]  r4_g, r4_h;
    logic                  r4_sat;
    t_ctx                  r4_ctx;

    t_pq w_pu, w_pv;
    logic w_keep;

    // round the quotient to 24 fraction bits, apply sign, clamp to 32 bits
    function automatic t_pq pq(input logic [QW-1:0] q, input logic ovf, input logic neg);
        logic [QW:0]   qp;
        logic [QW-1:0] m;
        t_pq           o;
        qp = {1'b0, q} + (QW+1)'(1);
        m  = qp[QW:1];
        o.sat = 1'b0;
        if (ovf) begin
            o.sat = 1'b1;
            o.val = neg ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
        end else if (!neg) begin
            if (m[QW-1:PW-1] != '0) begin
                o.sat = 1'b1;
                o.val = {1'b0, {(PW-1){1'b1}}};
            end else begin
                o.val = m[PW-1:0];
            end
        end else begin
            if ((m[QW-1:PW-1] != '0) && (m[PW-2:0] != '0 || m[QW-1:PW] != '0)) begin
                o.sat = 1'b1;
                o.val = {1'b1, {(PW-1){1'b0}}};
            end else begin
                o.val = PW'(0) - m[PW-1:0];
            end
        end
        return o;
    endfunction

    // product shifted down by 24, ties away from zero
    function automatic logic signed [RW-1:0] rnd(input logic signed [GPW-1:0] v);
        logic signed [GPW-1:0] t;
        t = v + (v[GPW-1] ? GPW'((1 << (PFRAC-1)) - 1) : GPW'(1 << (PFRAC-1)));
        return t[GPW-1:PFRAC];
    endfunction

    always_comb begin
        w_pu   = pq(i_div.u.q, i_div.ovf_u, i_div.neg_u);
        w_pv   = pq(i_div.v.q, i_div.ovf_v, i_div.neg_v);
        w_keep = i_div.ctx.proj && !i_div.ctx.sing;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    // stage 1: perspective terms, zero when affine or singular
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_g   <= w_keep ? w_pu.val : '0;
            r1_h   <= w_keep ? w_pv.val : '0;
            r1_sat <= w_keep && (w_pu.sat || w_pv.sat);
            r1_ctx <= i_div.ctx;
        end
    end

    // stage 2: perspective term times corner
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_pa  <= GPW'(r1_g) * GPW'(r1_ctx.x1);
            r2_pd  <= GPW'(r1_g) * GPW'(r1_ctx.y1);
            r2_pb  <= GPW'(r1_h) * GPW'(r1_ctx.x3);
            r2_pe  <= GPW'(r1_h) * GPW'(r1_ctx.y3);
            r2_g   <= r1_g;
            r2_h   <= r1_h;
            r2_sat <= r1_sat;
            r2_ctx <= r1_ctx;
        end
    end

    // stage 3: rounding
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_ra  <= rnd(r2_pa);
            r3_rd  <= rnd(r2_pd);
            r3_rb  <= rnd(r2_pb);
            r3_re  <= rnd(r2_pe);
            r3_g   <= r2_g;
            r3_h   <= r2_h;
            r3_sat <= r2_sat;
            r3_ctx <= r2_ctx;
        end
    end

    // stage 4: add base; the sum always fits in the coefficient width
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_a   <= CW'(r3_ra) + CW'(r3_ctx.ba);
            r4_d   <= CW'(r3_rd) + CW'(r3_ctx.bd);
            r4_b   <= CW'(r3_rb) + CW'(r3_ctx.bb);
            r4_e   <= CW'(r3_re) + CW'(r3_ctx.be);
            r4_g   <= r3_g;
            r4_h   <= r3_h;
            r4_sat <= r3_sat;
            r4_ctx <= r3_ctx;
        end
    end

    // result and status
    always_comb begin
        o_res.u_dx = r4_a;
        o_res.u_dy = r4_d;
        o_res.v_dx = r4_b;
        o_res.v_dy = r4_e;
        o_res.ox   = r4_ctx.x0;
        o_res.oy   = r4_ctx.y0;
        o_res.pu   = r4_g;
        o_res.pv   = r4_h;
        o_res.proj = r4_ctx.proj;
        if (r4_ctx.sing) begin
            o_res.status = ST_SING;
        end else if ((r4_a == '0 && r4_d == '0) || (r4_b == '0 && r4_e == '0)) begin
            o_res.status = ST_EDGE;
        end else if (r4_sat) begin
            o_res.status = ST_SAT;
        end else begin
            o_res.status = ST_OK;
        end
    end

    assign o_valid = r_v[3];

endmodule

`default_nettype wire

### sv/square_to_quad_projective_setup_top.sv
// top level: tolerance register, front stages, divider steps, back stages, output queue
// depends on sqp_pkg, sqp_front, sqp_div_step, sqp_back
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_stall    i_ul_x .. i_lr_y
//  result    out        o_valid / i_stall    o_u_dx .. o_status
//  config    in         i_cfg_we             i_cfg_wdata
//
// one quad enters per cycle while o_stall is low
// each request passes 5 front stages, 33 divider steps (one quotient bit each), 4 back stages
// and the output queue, the first stage being loaded at the accepting edge
// reset clears all valid bits, the output queue and the tolerance register
// a two-entry output queue parts the sides; the pipeline holds only when the queue is full
`default_nettype none

module square_to_quad_projective_setup_top
    import sqp_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire [TOL_W-1:0]        i_cfg_wdata,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  wire t_coord            i_ul_x,
    input  wire t_coord            i_ul_y,
    input  wire t_coord            i_ur_x,
    input  wire t_coord            i_ur_y,
    input  wire t_coord            i_ll_x,
    input  wire t_coord            i_ll_y,
    input  wire t_coord            i_lr_x,
    input  wire t_coord            i_lr_y,
    output logic                   o_valid,
    input  wire                    i_stall,
    output logic signed [CW-1:0]   o_u_dx,
    output logic signed [CW-1:0]   o_u_dy,
    output logic signed [CW-1:0]   o_v_dx,
    output logic signed [CW-1:0]   o_v_dy,
    output t_coord                 o_origin_x,
    output t_coord                 o_origin_y,
    output logic signed [PW-1:0]   o_persp_u,
    output logic signed [PW-1:0]   o_persp_v,
    output logic                   o_is_projective,
    output logic [1:0]             o_status
);

    logic [TOL_W-1:0] r_tol;
    logic             w_en;
    logic             w_dv [QW+1];
    t_div             w_div [QW+1];
    logic             w_bv;
    t_res             w_res;

    t_res             r_q [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             w_push, w_pop;
    t_res             w_head;

    // tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= '0;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    // the whole pipeline advances while the queue has room
    assign w_en    = (r_cnt != 2'd2);
    assign o_stall = !w_en;

    sqp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_tol   (r_tol),
        .i_ul_x  (i_ul_x),
        .i_ul_y  (i_ul_y),
        .i_ur_x  (i_ur_x),
        .i_ur_y  (i_ur_y),
        .i_ll_x  (i_ll_x),
        .i_ll_y  (i_ll_y),
        .i_lr_x  (i_lr_x),
        .i_lr_y  (i_lr_y),
        .o_valid (w_dv[0]),
        .o_div   (w_div[0])
    );

    // divider chain, one quotient bit per stage
    for (genvar k = 0; k < QW; k++) begin : g_div
        sqp_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_dv[k]),
            .i_st    (w_div[k]),
            .o_valid (w_dv[k+1]),
            .o_st    (w_div[k+1])
        );
    end

    sqp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_dv[QW]),
        .i_div   (w_div[QW]),
        .o_valid (w_bv),
        .o_res   (w_res)
    );

    // two-entry output queue
    assign w_push = w_bv && w_en;
    assign w_pop  = (r_cnt != 2'd0) && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_res;
        end
    end

    assign w_head          = r_q[r_rp];
    assign o_valid         = (r_cnt != 2'd0);
    assign o_u_dx          = w_head.u_dx;
    assign o_u_dy          = w_head.u_dy;
    assign o_v_dx          = w_head.v_dx;
    assign o_v_dy          = w_head.v_dy;
    assign o_origin_x      = w_head.ox;
    assign o_origin_y      = w_head.oy;
    assign o_persp_u       = w_head.pu;
    assign o_persp_v       = w_head.pv;
    assign o_is_projective = w_head.proj;
    assign o_status        = w_head.status;

`ifndef ASSERT_OFF
    // queue never overfills
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output queue overflow");

    // singular divisor gives zero perspective terms on the projective path
    a_sing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_SING) |-> (o_is_projective && o_persp_u == '0
            && o_persp_v == '0))
        else $error("singular result with nonzero perspective terms");

    // affine results carry no perspective terms and are never singular
    a_aff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_projective) |-> (o_persp_u == '0 && o_persp_v == '0
            && o_status != ST_SING))
        else $error("affine result with perspective terms");
`endif

endmodule

`default_nettype wire

### test/testbench.sv
// self-checking testbench for square_to_quad_projective_setup_top
// depends on sqp_pkg and the top level; predicts each result and checks it in order
`timescale 1ns / 100ps
`default_nettype none

module testbench;
    import sqp_pkg::*;

    typedef t_coord t_quad [8];

    // expected setup results, oldest first
    class setup_scoreboard;
        t_res pending[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch on %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        function longint unsigned magn(longint v);
            return v < 0 ? -v : v;
        endfunction

        function longint clamp(longint v, int w, inout bit sat);
            longint hi;
            longint lo;
            hi = (64'sd1 <<< (w - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) begin
                sat = 1;
                return hi;
            end
            if (v < lo) begin
                sat = 1;
                return lo;
            end
            return v;
        endfunction

        // round to nearest, ties away from zero, of v / 2^24
        function longint round_persp(longint v);
            longint unsigned m;
            m = (magn(v) + (64'd1 << (PFRAC - 1))) >> PFRAC;
            return v < 0 ? -longint'(m) : longint'(m);
        endfunction

        // num / den with 24 fraction bits, rounded and clamped
        function longint persp_quot(longint num, longint den, inout bit sat);
            longint unsigned n, d, q, r, frac, m;
            bit neg;
            n = magn(num);
            d = magn(den);
            neg = (num < 0) != (den < 0);
            frac = 0;
            q = n / d;
            if (q >= 256) begin
                m = 64'd1 << 40;
            end else begin
                r = n % d;
                for (int i = 0; i <= PFRAC; i++) begin
                    r = r << 1;
                    frac = frac << 1;
                    if (r >= d) begin
                        r = r - d;
                        frac = frac | 1;
                    end
                end
                m = (((q << (PFRAC + 1)) | frac) + 1) >> 1;
            end
            return clamp(neg ? -longint'(m) : longint'(m), PW, sat);
        endfunction

        // work out the mapping for one accepted request
        function void note_request(t_quad c, int unsigned tol);
            longint x0, y0, x1, y1, x3, y3, x2, y2, mx, my;
            longint a, b, d, e, g, h, e1x, e2x, e1y, e2y, den;
            bit sat, sing, proj;
            t_res res;
            x0 = c[0]; y0 = c[1]; x1 = c[2]; y1 = c[3];
            x3 = c[4]; y3 = c[5]; x2 = c[6]; y2 = c[7];
            mx = x0 - x1 + x2 - x3;
            my = y0 - y1 + y2 - y3;
            g = 0; h = 0; sat = 0; sing = 0;
            proj = !(magn(mx) <= tol && magn(my) <= tol);
            if (!proj) begin
                a = x1 - x0;
                b = x2 - x1;
                d = y1 - y0;
                e = y2 - y1;
            end else begin
                e1x = x1 - x2; e2x = x3 - x2; e1y = y1 - y2; e2y = y3 - y2;
                den = e1x * e2y - e1y * e2x;
                if (den == 0) begin
                    sing = 1;
                end else begin
                    g = persp_quot(mx * e2y - my * e2x, den, sat);
                    h = persp_quot(e1x * my - e1y * mx, den, sat);
                end
                a = x1 - x0 + round_persp(g * x1);
                b = x3 - x0 + round_persp(h * x3);
                d = y1 - y0 + round_persp(g * y1);
                e = y3 - y0 + round_persp(h * y3);
            end
            a = clamp(a, CW, sat);
            b = clamp(b, CW, sat);
            d = clamp(d, CW, sat);
            e = clamp(e, CW, sat);
            res.u_dx = CW'(a);
            res.u_dy = CW'(d);
            res.v_dx = CW'(b);
            res.v_dy = CW'(e);
            res.ox = c[0];
            res.oy = c[1];
            res.pu = PW'(g);
            res.pv = PW'(h);
            res.proj = proj;
            if (sing)
                res.status = ST_SING;
            else if ((a == 0 && d == 0) || (b == 0 && e == 0))
                res.status = ST_EDGE;
            else if (sat)
                res.status = ST_SAT;
            else
                res.status = ST_OK;
            pending.insert(pending.size(), res);
        endfunction

        // compare one taken result with the oldest expectation
        task check_result(t_res got);
            t_res want;
            if (pending.size() == 0) begin
                $display("unexpected result with nothing pending");
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.u_dx !== want.u_dx) report("u_dx", got.u_dx, want.u_dx);
            if (got.u_dy !== want.u_dy) report("u_dy", got.u_dy, want.u_dy);
            if (got.v_dx !== want.v_dx) report("v_dx", got.v_dx, want.v_dx);
            if (got.v_dy !== want.v_dy) report("v_dy", got.v_dy, want.v_dy);
            if (got.ox !== want.ox) report("origin_x", got.ox, want.ox);
            if (got.oy !== want.oy) report("origin_y", got.oy, want.oy);
            if (got.pu !== want.pu) report("persp_u", got.pu, want.pu);
            if (got.pv !== want.pv) report("persp_v", got.pv, want.pv);
            if (got.proj !== want.proj) report("is_projective", got.proj, want.proj);
            if (got.status !== want.status) report("status", got.status, want.status);
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [TOL_W-1:0]  i_cfg_wdata;
    logic              i_valid;
    logic              o_stall;
    t_coord            i_ul_x, i_ul_y, i_ur_x, i_ur_y, i_ll_x, i_ll_y, i_lr_x, i_lr_y;
    logic              o_valid;
    logic              i_stall;
    logic signed [CW-1:0] o_u_dx, o_u_dy, o_v_dx, o_v_dy;
    t_coord            o_origin_x, o_origin_y;
    logic signed [PW-1:0] o_persp_u, o_persp_v;
    logic              o_is_projective;
    logic [1:0]        o_status;

    setup_scoreboard   sb;
    int unsigned       tol_now;
    int                hold_cycles;
    bit                no_gaps;
    int                burst_left;

    square_to_quad_projective_setup_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_ul_x(i_ul_x), .i_ul_y(i_ul_y), .i_ur_x(i_ur_x), .i_ur_y(i_ur_y),
        .i_ll_x(i_ll_x), .i_ll_y(i_ll_y), .i_lr_x(i_lr_x), .i_lr_y(i_lr_y),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_u_dx(o_u_dx), .o_u_dy(o_u_dy), .o_v_dx(o_v_dx), .o_v_dy(o_v_dy),
        .o_origin_x(o_origin_x), .o_origin_y(o_origin_y),
        .o_persp_u(o_persp_u), .o_persp_v(o_persp_v),
        .o_is_projective(o_is_projective), .o_status(o_status)
    );

    // clock
    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

    // receiver stall pattern, with a long hold on request
    initial begin
        int mode;
        int left;
        i_stall = 0;
        mode = 0;
        left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_stall <= 1;
                hold_cycles--;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(10, 80);
                end
                left--;
                case (mode)
                    0: i_stall <= 0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    2: i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_res got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.u_dx = o_u_dx;
            got.u_dy = o_u_dy;
            got.v_dx = o_v_dx;
            got.v_dy = o_v_dy;
            got.ox = o_origin_x;
            got.oy = o_origin_y;
            got.pu = o_persp_u;
            got.pv = o_persp_v;
            got.proj = o_is_projective;
            got.status = o_status;
            sb.check_result(got);
        end
    end

    // offer one quad, wait until taken, then maybe leave a gap
    task send_quad(t_quad c);
        int gap;
        i_valid <= 1;
        i_ul_x <= c[0]; i_ul_y <= c[1]; i_ur_x <= c[2]; i_ur_y <= c[3];
        i_ll_x <= c[4]; i_ll_y <= c[5]; i_lr_x <= c[6]; i_lr_y <= c[7];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(c, tol_now);
        if (burst_left > 0) begin
            burst_left--;
        end else if (!no_gaps) begin
            burst_left = $urandom_range(0, 12);
            gap = $urandom_range(1, 6);
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // let every pending result drain
    task drain;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task write_tolerance(int unsigned v);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_wdata <= TOL_W'(v);
        @(posedge i_clk);
        i_cfg_we <= 0;
        tol_now = v;
    endtask

    function t_coord rnd_coord(int kind);
        case (kind)
            0: return t_coord'($urandom);
            1: return t_coord'($signed($urandom_range(0, 8191)) - 4096);
            default: return t_coord'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
        endcase
    endfunction

    // random quad: half near parallelograms, plus wild and degenerate ones
    function t_quad rnd_quad();
        t_quad c;
        int kind;
        int sel;
        sel = $urandom_range(0, 9);
        kind = $urandom_range(0, 2);
        for (int i = 0; i < 8; i++) c[i] = rnd_coord(kind);
        if (sel < 5) begin
            c[6] = t_coord'(c[2] + c[4] - c[0] + ($signed($urandom_range(0, 600)) - 300));
            c[7] = t_coord'(c[3] + c[5] - c[1] + ($signed($urandom_range(0, 600)) - 300));
        end else if (sel == 5) begin
            c[2] = c[0];
            c[3] = c[1];
        end else if (sel == 6) begin
            c[4] = c[6];
            c[5] = c[7];
        end
        return c;
    endfunction

    function t_quad mk(int a0, int a1, int a2, int a3, int a4, int a5, int a6, int a7);
        t_quad c;
        c[0] = t_coord'(a0); c[1] = t_coord'(a1); c[2] = t_coord'(a2); c[3] = t_coord'(a3);
        c[4] = t_coord'(a4); c[5] = t_coord'(a5); c[6] = t_coord'(a6); c[7] = t_coord'(a7);
        return c;
    endfunction

    // directed quads: extremes, shapes and special cases
    task directed;
        int mx;
        int mn;
        mx = 134217727;
        mn = -134217728;
        send_quad(mk(0, 0, 256, 0, 0, 256, 256, 256));
        send_quad(mk(0, 0, 0, 0, 0, 0, 0, 0));
        send_quad(mk(mx, mx, mx, mx, mx, mx, mx, mx));
        send_quad(mk(mn, mn, mn, mn, mn, mn, mn, mn));
        send_quad(mk(mx, mn, mn, mx, mx, mn, mn, mx));
        send_quad(mk(mn, mx, mx, mn, mx, mn, mn, mx));
        send_quad(mk(mn, mn, mx, mn, mn, mx, mx, mx));
        send_quad(mk(0, 0, 1024, 100, 100, 900, 800, 700));
        send_quad(mk(-500, 300, 2000, -100, -800, 1500, 2500, 1800));
        // zero-length edge column
        send_quad(mk(100, 100, 100, 100, 300, 500, 700, 900));
        send_quad(mk(0, 0, 512, 0, 700, 800, 700, 800));
        // singular divisor: collinear corners with a mismatch
        send_quad(mk(1000, 0, 256, 0, 512, 0, 0, 0));
        send_quad(mk(7, 7, 3, 3, 9, 9, 1, 1));
        // huge perspective, saturating quotient
        send_quad(mk(0, 0, 1, 0, 0, 1, mx, mx));
        send_quad(mk(mn, 0, 2, 1, 1, 3, mx, mn));
        send_quad(mk(0, 0, 256, 1, 1, 256, 255, 255));
        send_quad(mk(-1, -1, 1, -1, -1, 1, 1, 1));
    endtask

    // main sequence
    initial begin
        int unsigned tols [5];
        sb = new();
        hold_cycles = 0;
        no_gaps = 0;
        burst_left = 0;
        tol_now = 0;
        i_rst_n <= 0;
        i_cfg_we <= 0;
        i_cfg_wdata <= 0;
        i_valid <= 0;
        i_ul_x <= 0; i_ul_y <= 0; i_ur_x <= 0; i_ur_y <= 0;
        i_ll_x <= 0; i_ll_y <= 0; i_lr_x <= 0; i_lr_y <= 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        repeat (2) @(posedge i_clk);

        tols[0] = 0;
        tols[1] = 65535;
        tols[2] = $urandom_range(1, 400);
        tols[3] = 1;
        tols[4] = $urandom_range(0, 65535);
        for (int p = 0; p < 5; p++) begin
            // the tolerance register is only touched with the pipeline empty
            write_tolerance(tols[p]);
            if (p == 0 || p == 1) directed();
            for (int n = 0; n < 140; n++) begin
                if (p == 2 && n == 20) begin
                    // long receiver hold while requests keep coming
                    no_gaps = 1;
                    hold_cycles = 300;
                end
                if (p == 2 && n == 90) no_gaps = 0;
                if (p == 3 && n == 70) begin
                    i_valid <= 0;
                    drain();
                end
                if (p == 4 && n < 40) no_gaps = 1;
                else if (p == 4) no_gaps = 0;
                send_quad(rnd_quad());
            end
            i_valid <= 0;
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
